>>> src/mad_pkg.sv
// mad_pkg: shared sizes, key type and sorting-cell control struct for the
// median / median absolute deviation core; used by every file in src
`timescale 1ns / 1ps
`default_nettype none

package mad_pkg;

    localparam int MAX_SAMPLES  = 64;
    localparam int SAMPLE_BITS  = 16;

    localparam int ADDR_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int KEY_W        = SAMPLE_BITS + 2;
    localparam int MED_W        = SAMPLE_BITS + 1;
    localparam int MAD_W        = SAMPLE_BITS + 2;

    localparam int IN_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = MED_W + MAD_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // sort key: samples sign-extended, deviations zero-extended
    typedef logic signed [KEY_W-1:0] key_t;

    typedef struct packed {
        logic insert;
        logic drain;
        logic clear;
    } cell_ctrl_t;

endpackage : mad_pkg

`default_nettype wire

>>> src/mad_cell.sv
// mad_cell: one cell of the insertion sorting chain, holds one key
// depends on mad_pkg
`timescale 1ns / 1ps
`default_nettype none

module mad_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mad_pkg::cell_ctrl_t ctrl,
    input  wire mad_pkg::key_t       new_key,
    input  wire mad_pkg::key_t       left_key,
    input  wire logic                left_gt,
    input  wire logic                left_valid,
    input  wire mad_pkg::key_t       right_key,
    output mad_pkg::key_t            key,
    output logic                     valid,
    output logic                     gt
);

    mad_pkg::key_t key_reg;
    logic          valid_reg;

    // new key belongs in front of this cell
    assign gt    = !valid_reg || (new_key < key_reg);
    assign key   = key_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert)
        begin
            valid_reg <= valid_reg | left_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert && gt)
        begin
            key_reg <= left_gt ? left_key : new_key;
        end
        else if (ctrl.drain)
        begin
            key_reg <= right_key;
        end
    end

endmodule : mad_cell

`default_nettype wire

>>> src/mad_chain.sv
// mad_chain: row of mad_cell sorting cells, ascending from the head
// depends on mad_pkg and mad_cell
`timescale 1ns / 1ps
`default_nettype none

module mad_chain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mad_pkg::cell_ctrl_t ctrl,
    input  wire mad_pkg::key_t       new_key,
    output mad_pkg::key_t            head_key
);

    mad_pkg::key_t keys   [0:mad_pkg::MAX_SAMPLES-1];
    logic          valids [0:mad_pkg::MAX_SAMPLES-1];
    logic          gts    [0:mad_pkg::MAX_SAMPLES-1];

    mad_pkg::key_t lkey   [0:mad_pkg::MAX_SAMPLES-1];
    mad_pkg::key_t rkey   [0:mad_pkg::MAX_SAMPLES-1];
    logic          lgt    [0:mad_pkg::MAX_SAMPLES-1];
    logic          lvalid [0:mad_pkg::MAX_SAMPLES-1];

    genvar g;
    generate
        for (g = 0; g < mad_pkg::MAX_SAMPLES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign lkey[g]   = '0;
                assign lgt[g]    = 1'b0;
                assign lvalid[g] = 1'b1;
            end
            else
            begin : g_body
                assign lkey[g]   = keys[g-1];
                assign lgt[g]    = gts[g-1];
                assign lvalid[g] = valids[g-1];
            end

            if (g == mad_pkg::MAX_SAMPLES - 1)
            begin : g_tail
                assign rkey[g] = '0;
            end
            else
            begin : g_inner
                assign rkey[g] = keys[g+1];
            end

            mad_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_key    (new_key),
                .left_key   (lkey[g]),
                .left_gt    (lgt[g]),
                .left_valid (lvalid[g]),
                .right_key  (rkey[g]),
                .key        (keys[g]),
                .valid      (valids[g]),
                .gt         (gts[g])
            );
        end
    endgenerate

    assign head_key = keys[0];

endmodule : mad_chain

`default_nettype wire

>>> src/median_and_mad_core.sv
// median_and_mad_core: top level, median and median absolute deviation of a set
// depends on mad_pkg and mad_chain (which uses mad_cell)
//
//  channel   dir  signals                       contents
//  s_axis    in   tvalid tready tdata tlast     tdata[15:0] sample, tlast ends the set
//  m_axis    out  tvalid tready tdata tuser     tdata: median_x2, mad_x4, count;
//                                               tuser: overflowed
//
//  sequence: a set of n kept samples loads one request per cycle, then the
//  sorted chain drains to its middle, the sample store is replayed into the
//  chain as deviations, and the chain drains to its middle again; the result
//  then loads into the output register once that is free, and the single
//  insertion chain serves both sorts
//  reset: asynchronous, clears control state only; the sample store is not
//  cleared, since it is read only after it is written in the same set
//  stalls: input is taken only while loading; a finished result waits in the
//  output register, and the next set may load meanwhile
`timescale 1ns / 1ps
`default_nettype none

module median_and_mad_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [mad_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] sample
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [16:0] median_x2, [34:17] mad_x4, [41:35] count, rest zero
    output logic [mad_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic [0:0]                            m_axis_tuser   // [0] overflowed
);

    // state codes
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_MED  = 3'd1;  // drain chain down to the median
    localparam logic [2:0] ST_DEV  = 3'd2;  // replay store as abs deviations
    localparam logic [2:0] ST_MAD  = 3'd3;  // drain chain down to the mad

    localparam int CW = mad_pkg::CNT_W;
    localparam int KW = mad_pkg::KEY_W;
    localparam int SW = mad_pkg::SAMPLE_BITS;

    logic [2:0]                  state_reg, state_next;

    // set bookkeeping
    logic [CW-1:0]               fill_reg;
    logic                        ovf_reg;
    logic [CW-1:0]               n_reg;
    logic [CW-1:0]               mid_reg;
    logic                        odd_reg;
    logic                        set_ovf_reg;

    // drain and replay counters
    logic [CW-1:0]               k_reg;
    logic [CW-1:0]               r_reg;

    // replay pipeline
    logic [SW-1:0]               rdata_reg;
    logic                        rd_v_reg;
    logic [KW-2:0]               dev_reg;
    logic                        dev_v_reg;

    logic signed [KW-1:0]        lo_reg;
    logic [mad_pkg::MED_W-1:0]   med2_reg;

    // output register
    logic                        out_valid_reg;
    logic [mad_pkg::MED_W-1:0]   out_med_reg;
    logic [mad_pkg::MAD_W-1:0]   out_mad_reg;
    logic [CW-1:0]               out_cnt_reg;
    logic                        out_ovf_reg;

    // sample store
    logic [SW-1:0]               store_mem [0:mad_pkg::MAX_SAMPLES-1];

    mad_pkg::cell_ctrl_t         chain_ctrl;
    mad_pkg::key_t               chain_key;
    mad_pkg::key_t               head_key;

    logic                        in_acc;
    logic                        keep;
    logic [CW-1:0]               fill_inc;
    logic                        at_mid;
    logic                        pre_mid;
    logic                        issue;
    logic                        out_free;
    logic                        out_load;
    logic signed [KW-1:0]        pick;
    logic signed [KW-1:0]        twice_s;
    logic signed [KW-1:0]        med_ext;
    logic signed [KW-1:0]        diff;
    mad_pkg::key_t               sample_key;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign keep          = (fill_reg < CW'(mad_pkg::MAX_SAMPLES));
    assign fill_inc      = fill_reg + 1'b1;

    assign at_mid  = (k_reg == mid_reg);
    assign pre_mid = ((k_reg + 1'b1) == mid_reg);
    assign issue   = (state_reg == ST_DEV) && (r_reg != n_reg);

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_MAD) && at_mid && out_free;

    // middle value, or the mean of the two middle values, times two
    assign pick = odd_reg ? (head_key <<< 1) : (lo_reg + head_key);

    // deviation from the median, in half units
    assign sample_key = {{(KW-SW){s_axis_tdata[SW-1]}}, s_axis_tdata[SW-1:0]};
    assign twice_s    = {{(KW-SW-1){rdata_reg[SW-1]}}, rdata_reg, 1'b0};
    assign med_ext    = {{(KW-mad_pkg::MED_W){med2_reg[mad_pkg::MED_W-1]}}, med2_reg};
    assign diff       = twice_s - med_ext;

    // chain control: load inserts samples, replay inserts deviations
    always_comb
    begin
        chain_ctrl.insert = (in_acc && keep) || dev_v_reg;
        chain_ctrl.drain  = ((state_reg == ST_MED) || (state_reg == ST_MAD)) && !at_mid;
        chain_ctrl.clear  = ((state_reg == ST_MED) && at_mid) || out_load;
        chain_key         = dev_v_reg ? mad_pkg::key_t'({1'b0, dev_reg}) : sample_key;
    end

    mad_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chain_ctrl),
        .new_key  (chain_key),
        .head_key (head_key)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = ST_MED;
                end
            end
            ST_MED:
            begin
                if (at_mid)
                begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                if (!issue && !rd_v_reg && !dev_v_reg)
                begin
                    state_next = ST_MAD;
                end
            end
            ST_MAD:
            begin
                if (out_load)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            r_reg         <= '0;
            rd_v_reg      <= 1'b0;
            dev_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            dev_v_reg <= rd_v_reg;

            if (in_acc)
            begin
                if (s_axis_tlast)
                begin
                    // set closes, bookkeeping restarts for the next one
                    fill_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
                else if (keep)
                begin
                    fill_reg <= fill_inc;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (state_next != state_reg)
            begin
                k_reg <= '0;
            end
            else if (chain_ctrl.drain)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (state_reg != ST_DEV)
            begin
                r_reg <= '0;
            end
            else if (issue)
            begin
                r_reg <= r_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tlast)
        begin
            n_reg       <= keep ? fill_inc : fill_reg;
            mid_reg     <= (keep ? fill_inc : fill_reg) >> 1;
            odd_reg     <= keep ? fill_inc[0] : fill_reg[0];
            set_ovf_reg <= ovf_reg | !keep;
        end

        if (chain_ctrl.drain && pre_mid)
        begin
            lo_reg <= head_key;
        end

        if ((state_reg == ST_MED) && at_mid)
        begin
            med2_reg <= pick[mad_pkg::MED_W-1:0];
        end

        if (rd_v_reg)
        begin
            dev_reg <= diff[KW-1] ? (KW-1)'(-diff) : diff[KW-2:0];
        end

        if (out_load)
        begin
            out_med_reg <= med2_reg;
            out_mad_reg <= pick[mad_pkg::MAD_W-1:0];
            out_cnt_reg <= n_reg;
            out_ovf_reg <= set_ovf_reg;
        end
    end

    // sample store, registered read
    always_ff @(posedge clk)
    begin
        if (in_acc && keep)
        begin
            store_mem[fill_reg[mad_pkg::ADDR_W-1:0]] <= s_axis_tdata[SW-1:0];
        end
        if (issue)
        begin
            rdata_reg <= store_mem[r_reg[mad_pkg::ADDR_W-1:0]];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mad_pkg::OUT_DATA_W - mad_pkg::OUT_FIELDS_W){1'b0}},
                            out_cnt_reg, out_mad_reg, out_med_reg};
    assign m_axis_tuser  = out_ovf_reg;

    // the chain never shifts and inserts in the same cycle
    a_no_insert_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !(chain_ctrl.insert && chain_ctrl.drain))
        else $error("chain insert and drain together");

    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(mad_pkg::MAX_SAMPLES))
        else $error("fill count beyond store depth");

    // drains stop at the middle
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MED) || (state_reg == ST_MAD)) |-> (k_reg <= mid_reg))
        else $error("drain ran past the middle");

    // replay reads happen only during the deviation pass
    a_replay_state: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> (state_reg == ST_DEV))
        else $error("store read outside replay");

    // a delivered result always covers at least one sample
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_cnt_reg != '0))
        else $error("result with empty set");

endmodule : median_and_mad_core

`default_nettype wire
